// File: src/periodic_task_dispatch_table_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task dispatch table
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCH_TABLE_MACROS_SVH
`define PERIODIC_TASK_DISPATCH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check that the consequent holds in the same cycle as the antecedent
`define PTDT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never holds
`define PTDT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define PTDT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define PTDT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/ptdt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task dispatch table package
// Shared sizes, operation codes and beat types for the dispatch table.
// ----------------------------------------------------------------------------
package ptdt_pkg;

  // Table depth and derived widths
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths
  localparam int FUNC_W    = 3;
  localparam int HANDLE_W  = 8;
  localparam int RATE_W    = 32;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 5;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  // Function codes on the input port
  localparam logic [FUNC_W-1:0] FUNC_ADD        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_ACTIVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_RATE   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESET      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RUN        = 3'd4;

  // Result kinds
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_FIRED  = 1'b1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  // Operation class decided by the front end
  typedef enum logic [2:0] {
    OPK_ADD,
    OPK_SET_ACTIVE,
    OPK_SET_RATE,
    OPK_RESET,
    OPK_RUN,
    OPK_BAD
  } op_kind_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_kind_t            kind;
    handle_t             task_id;
    logic [RATE_W-1:0]   rate;
    logic [TIME_W-1:0]   time_value;
    logic                active_flag;
  } cmd_t;

  // One table entry
  typedef struct packed {
    handle_t             handle;
    logic [RATE_W-1:0]   rate;
    logic [TIME_W-1:0]   run_stamp;
    logic                active;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic                result_kind;
    logic                ok;
    handle_t             handle;
    count_t              count;
    logic                last_of_run;
  } res_t;

  // Back end status
  typedef struct packed {
    logic                idle;
    cnt_t                used;
  } back_stat_t;

endpackage

// File: src/periodic_task_dispatch_table.sv
// ----------------------------------------------------------------------------
// Periodic task dispatch table
// Time-triggered table of periodic tasks with add, set, reset and run operations.
// ----------------------------------------------------------------------------
// A two-entry command queue takes input beats while the back end works, and a
// four-entry result queue lets the back end keep going while results wait.
// Add and rejected operations go straight to the closing status beat in the
// back end; set active, set rate and reset timer walk the table, stopping at
// the matching entry; run walks every task in the table. The walk goes through
// the task table's single read port, one entry per cycle while the result
// queue has room; a full result queue stalls the walk.
// Each run gives one beat per fired task in table order, then a closing status
// beat with last_of_run set.
`include "periodic_task_dispatch_table_macros.svh"

module periodic_task_dispatch_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [ptdt_pkg::FUNC_W-1:0]     in_func,
  input  logic [ptdt_pkg::HANDLE_W-1:0]   in_task_id,
  input  logic [ptdt_pkg::RATE_W-1:0]     in_rate,
  input  logic [ptdt_pkg::TIME_W-1:0]     in_time_value,
  input  logic                            in_active_flag,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_result_kind,
  output logic                            out_ok,
  output logic [ptdt_pkg::HANDLE_W-1:0]   out_handle,
  output logic [ptdt_pkg::COUNT_W-1:0]    out_count,
  output logic                            out_last_of_run
);

  logic                 cmd_valid;
  ptdt_pkg::cmd_t       cmd;
  logic                 cmd_pop;
  logic                 res_push;
  logic                 res_full;
  ptdt_pkg::res_t       res;
  ptdt_pkg::res_t       res_out;
  ptdt_pkg::back_stat_t stat;

  // Classify and queue commands
  ptdt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_func        (in_func),
    .in_task_id     (in_task_id),
    .in_rate        (in_rate),
    .in_time_value  (in_time_value),
    .in_active_flag (in_active_flag),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Carry out commands against the task table
  ptdt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .stat      (stat)
  );

  // Buffer result beats
  ptdt_res_fifo u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_result_kind = res_out.result_kind;
  assign out_ok          = res_out.ok;
  assign out_handle      = res_out.handle;
  assign out_count       = res_out.count;
  assign out_last_of_run = res_out.last_of_run;

  // Checks
  `PTDT_ASSERT_NEVER(a_used_bound, clk, rst_n,
    stat.used > ptdt_pkg::cnt_t'(ptdt_pkg::MAX_TASKS), "task count beyond table depth")
  `PTDT_ASSERT_IMPLIES(a_used_step, clk, rst_n, stat.used != $past(stat.used),
    stat.used == ptdt_pkg::cnt_t'($past(stat.used) + 1'b1),
    "task count moved by other than one add")
  `PTDT_ASSERT_IMPLIES(a_fired_not_last, clk, rst_n,
    !out_empty && out_result_kind == ptdt_pkg::RK_FIRED, !out_last_of_run && out_ok,
    "fired beat marked last or not ok")
  `PTDT_ASSERT_IMPLIES(a_idle_no_push, clk, rst_n, stat.idle, !res_push,
    "result beat pushed while back end idle")

endmodule

// File: src/ptdt_front.sv
// ----------------------------------------------------------------------------
// Dispatch table front end
// Accepts input beats, classifies the operation and queues the command.
// ----------------------------------------------------------------------------
module ptdt_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ptdt_pkg::FUNC_W-1:0]        in_func,
  input  ptdt_pkg::handle_t                  in_task_id,
  input  logic [ptdt_pkg::RATE_W-1:0]        in_rate,
  input  logic [ptdt_pkg::TIME_W-1:0]        in_time_value,
  input  logic                               in_active_flag,
  output logic                               cmd_valid,
  output ptdt_pkg::cmd_t                     cmd,
  input  logic                               cmd_pop
);

  localparam int PTR_W = (ptdt_pkg::CMDQ_DEPTH > 1) ? $clog2(ptdt_pkg::CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(ptdt_pkg::CMDQ_DEPTH + 1);

  ptdt_pkg::cmd_t    q_r [ptdt_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  ptdt_pkg::cmd_t    cls;
  logic              do_push;
  logic              do_pop;

  // Classify the incoming beat; zero rates on add and set rate are rejected here
  always_comb begin
    cls.task_id     = in_task_id;
    cls.rate        = in_rate;
    cls.time_value  = in_time_value;
    cls.active_flag = in_active_flag;
    case (in_func)
      ptdt_pkg::FUNC_ADD: begin
        cls.kind = (in_rate == '0) ? ptdt_pkg::OPK_BAD : ptdt_pkg::OPK_ADD;
      end
      ptdt_pkg::FUNC_SET_ACTIVE: begin
        cls.kind = ptdt_pkg::OPK_SET_ACTIVE;
      end
      ptdt_pkg::FUNC_SET_RATE: begin
        cls.kind = (in_rate == '0) ? ptdt_pkg::OPK_BAD : ptdt_pkg::OPK_SET_RATE;
      end
      ptdt_pkg::FUNC_RESET: begin
        cls.kind = ptdt_pkg::OPK_RESET;
      end
      ptdt_pkg::FUNC_RUN: begin
        cls.kind = ptdt_pkg::OPK_RUN;
      end
      default: begin
        cls.kind = ptdt_pkg::OPK_BAD;
      end
    endcase
  end

  // Queue handshake
  assign in_full   = (cnt_r == QCNT_W'(ptdt_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ptdt_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ptdt_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: src/ptdt_back.sv
// ----------------------------------------------------------------------------
// Dispatch table back end
// Owns the task table and walks it one entry per cycle, while the result queue has room, for run and lookups.
// ----------------------------------------------------------------------------
module ptdt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  ptdt_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output ptdt_pkg::res_t        res,
  output ptdt_pkg::back_stat_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_STATUS = 3'b100
  } state_t;

  ptdt_pkg::entry_t  mem [ptdt_pkg::MAX_TASKS];
  ptdt_pkg::entry_t  rd_data_r;

  state_t            state_r, state_nxt;
  ptdt_pkg::cmd_t    op_r, op_nxt;
  ptdt_pkg::cnt_t    rd_cnt_r, rd_cnt_nxt;
  logic              ev_vld_r, ev_vld_nxt;
  ptdt_pkg::idx_t    ev_idx_r, ev_idx_nxt;
  logic              found_r, found_nxt;
  ptdt_pkg::cnt_t    used_r, used_nxt;
  ptdt_pkg::handle_t next_handle_r, next_handle_nxt;

  logic              rd_en;
  logic              wr_en;
  ptdt_pkg::idx_t    wr_idx;
  ptdt_pkg::entry_t  wr_data;
  logic [ptdt_pkg::TIME_W-1:0] elapsed;
  logic              hit;
  logic              fire;
  logic              add_ok;
  logic              walk_op;
  logic              lookup_hit;

  // Evaluate the entry held in the read register
  assign elapsed = op_r.time_value - rd_data_r.run_stamp;
  assign hit     = (rd_data_r.handle == op_r.task_id);
  assign fire    = rd_data_r.active && (elapsed >= rd_data_r.rate);
  assign add_ok  = (used_r < ptdt_pkg::cnt_t'(ptdt_pkg::MAX_TASKS)) && (next_handle_r != '0);
  assign walk_op = (cmd.kind == ptdt_pkg::OPK_SET_ACTIVE) ||
                   (cmd.kind == ptdt_pkg::OPK_SET_RATE) ||
                   (cmd.kind == ptdt_pkg::OPK_RESET) ||
                   (cmd.kind == ptdt_pkg::OPK_RUN);
  assign lookup_hit = ev_vld_r && hit && (op_r.kind != ptdt_pkg::OPK_RUN);

  assign stat.idle = (state_r == S_IDLE);
  assign stat.used = used_r;

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    rd_cnt_nxt      = rd_cnt_r;
    ev_vld_nxt      = ev_vld_r;
    ev_idx_nxt      = ev_idx_r;
    found_nxt       = found_r;
    used_nxt        = used_r;
    next_handle_nxt = next_handle_r;
    cmd_pop         = 1'b0;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_idx          = ev_idx_r;
    wr_data         = rd_data_r;
    res_push        = 1'b0;
    res             = '0;
    case (state_r)
      S_IDLE: begin
        // Take the next command
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          op_nxt     = cmd;
          rd_cnt_nxt = '0;
          ev_vld_nxt = 1'b0;
          found_nxt  = 1'b0;
          state_nxt  = walk_op ? S_WALK : S_STATUS;
        end
      end
      S_WALK: begin
        // Stall the whole walk while the result queue is full
        if (!res_full) begin
          rd_en      = (rd_cnt_r < used_r);
          ev_vld_nxt = rd_en;
          ev_idx_nxt = rd_cnt_r[ptdt_pkg::IDX_W-1:0];
          if (rd_en) begin
            rd_cnt_nxt = rd_cnt_r + 1'b1;
          end
          if (ev_vld_r) begin
            case (op_r.kind)
              ptdt_pkg::OPK_RUN: begin
                if (fire) begin
                  wr_en              = 1'b1;
                  wr_data.run_stamp  = op_r.time_value;
                  res_push           = 1'b1;
                  res.result_kind    = ptdt_pkg::RK_FIRED;
                  res.ok             = 1'b1;
                  res.handle         = rd_data_r.handle;
                  res.count          = ptdt_pkg::count_t'(used_r);
                  res.last_of_run    = 1'b0;
                end
              end
              ptdt_pkg::OPK_SET_ACTIVE: begin
                if (hit) begin
                  wr_en          = 1'b1;
                  wr_data.active = op_r.active_flag;
                  found_nxt      = 1'b1;
                end
              end
              ptdt_pkg::OPK_SET_RATE: begin
                if (hit) begin
                  wr_en        = 1'b1;
                  wr_data.rate = op_r.rate;
                  found_nxt    = 1'b1;
                end
              end
              ptdt_pkg::OPK_RESET: begin
                if (hit) begin
                  wr_en             = 1'b1;
                  wr_data.run_stamp = op_r.time_value;
                  found_nxt         = 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
          // Finish on a lookup match or when the walk has drained
          if (lookup_hit || (!rd_en && !ev_vld_r)) begin
            ev_vld_nxt = 1'b0;
            state_nxt  = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        // Emit the closing status beat and apply add
        if (!res_full) begin
          res_push        = 1'b1;
          res.result_kind = ptdt_pkg::RK_STATUS;
          res.last_of_run = 1'b1;
          state_nxt       = S_IDLE;
          case (op_r.kind)
            ptdt_pkg::OPK_ADD: begin
              if (add_ok) begin
                wr_en             = 1'b1;
                wr_idx            = used_r[ptdt_pkg::IDX_W-1:0];
                wr_data.handle    = next_handle_r;
                wr_data.rate      = op_r.rate;
                wr_data.run_stamp = op_r.time_value;
                wr_data.active    = 1'b1;
                used_nxt          = used_r + 1'b1;
                next_handle_nxt   = next_handle_r + 1'b1;
                res.ok            = 1'b1;
                res.handle        = next_handle_r;
              end
            end
            ptdt_pkg::OPK_RUN: begin
              res.ok = 1'b1;
            end
            ptdt_pkg::OPK_SET_ACTIVE, ptdt_pkg::OPK_SET_RATE, ptdt_pkg::OPK_RESET: begin
              res.ok = found_r;
            end
            default: begin
              res.ok = 1'b0;
            end
          endcase
          res.count = ptdt_pkg::count_t'(used_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rd_cnt_r      <= '0;
      ev_vld_r      <= 1'b0;
      found_r       <= 1'b0;
      used_r        <= '0;
      next_handle_r <= ptdt_pkg::handle_t'(1);
    end else begin
      state_r       <= state_nxt;
      rd_cnt_r      <= rd_cnt_nxt;
      ev_vld_r      <= ev_vld_nxt;
      found_r       <= found_nxt;
      used_r        <= used_nxt;
      next_handle_r <= next_handle_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    ev_idx_r <= ev_idx_nxt;
  end

  // Task table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_cnt_r[ptdt_pkg::IDX_W-1:0]];
    end
  end

endmodule

// File: src/ptdt_res_fifo.sv
// ----------------------------------------------------------------------------
// Dispatch table result queue
// Holds result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module ptdt_res_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ptdt_pkg::res_t  din,
  output logic            full,
  input  logic            pop,
  output ptdt_pkg::res_t  dout,
  output logic            empty
);

  localparam int PTR_W  = (ptdt_pkg::RESQ_DEPTH > 1) ? $clog2(ptdt_pkg::RESQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(ptdt_pkg::RESQ_DEPTH + 1);

  ptdt_pkg::res_t    q_r [ptdt_pkg::RESQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == QCNT_W'(ptdt_pkg::RESQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ptdt_pkg::RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ptdt_pkg::RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold result beats
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= din;
    end
  end

endmodule
